/* rtl/core/bsag_pkg.sv */
// ----------------------------------------------------------------------------
// bsag_pkg
// Shared constants, types and helpers of the block scatter address generator.
// ----------------------------------------------------------------------------
package bsag_pkg;

  localparam int Rank       = 4;
  localparam int ExtentBits = 12;

  localparam int NumFields  = 4;
  localparam int OffW       = 12;
  localparam int ExtW       = 13;
  localparam int AddrW      = 48;
  localparam int ValW       = 64;
  localparam int CfgIdxW    = $clog2(NumFields);

  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic {
    ST_RUN,
    ST_SETUP
  } bsag_state_t;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_SPAN,
    PH_STRIDE
  } bsag_phase_t;

  typedef struct packed {
    logic                                is_elem;
    logic [NumFields-1:0][OffW-1:0]      offset;
    logic [NumFields-1:0][ExtW-1:0]      bext;
    logic [ValW-1:0]                     value;
  } bsag_item_t;

  // zero reads as one, anything above 2^eb reads as 2^eb
  function automatic logic [ExtW-1:0] clamp_ext(input logic [ExtW-1:0] e,
                                                input int unsigned     eb);
    logic [31:0]     lim;
    logic [ExtW-1:0] r;
    lim = 32'd1 << eb;
    r   = e;
    if (e == '0) begin
      r = ExtW'(1);
    end else if (32'(e) > lim) begin
      r = ExtW'(lim);
    end
    return r;
  endfunction

endpackage

/* rtl/core/bsag_if.sv */
// ----------------------------------------------------------------------------
// bsag_in_if / bsag_out_if
// Valid/ready channels for command words in and address words out.
// ----------------------------------------------------------------------------
interface bsag_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] offset_0;
  logic [11:0] offset_1;
  logic [11:0] offset_2;
  logic [11:0] offset_3;
  logic [12:0] block_extent_0;
  logic [12:0] block_extent_1;
  logic [12:0] block_extent_2;
  logic [12:0] block_extent_3;
  logic [63:0] element_value;

  modport source (
    output valid, command, offset_0, offset_1, offset_2, offset_3,
           block_extent_0, block_extent_1, block_extent_2, block_extent_3,
           element_value,
    input  ready
  );
  modport sink (
    input  valid, command, offset_0, offset_1, offset_2, offset_3,
           block_extent_0, block_extent_1, block_extent_2, block_extent_3,
           element_value,
    output ready
  );
endinterface

interface bsag_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] dense_address;
  logic [63:0] out_value;
  logic        last_in_block;

  modport source (
    output valid, dense_address, out_value, last_in_block,
    input  ready
  );
  modport sink (
    input  valid, dense_address, out_value, last_in_block,
    output ready
  );
endinterface

/* rtl/core/bsag_front.sv */
// ----------------------------------------------------------------------------
// bsag_front
// Accepts command words, clamps extents, holds the dense extent registers and
// queues decoded words for the back end.
// ----------------------------------------------------------------------------
module bsag_front import bsag_pkg::*; #(
  parameter int EXTENT_BITS = ExtentBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bsag_in_if.sink                       in_ch,
  input  logic                          cfg_we,
  input  logic [CfgIdxW-1:0]            cfg_index,
  input  logic [ExtW-1:0]               cfg_data,
  output logic                          q_valid,
  output bsag_item_t                    q_item,
  input  logic                          q_pop,
  output logic [NumFields-1:0][ExtW-1:0] dext
);

  logic [NumFields-1:0][ExtW-1:0] dext_r;
  bsag_item_t                     q_mem_r [QueueDepth];
  logic [QPtrW-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]               cnt_r, cnt_nxt;
  bsag_item_t                     in_item;
  logic                           push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumFields; i++) begin
        dext_r[i] <= ExtW'(1);
      end
    end else if (cfg_we) begin
      dext_r[cfg_index] <= clamp_ext(cfg_data, EXTENT_BITS);
    end
  end

  assign dext = dext_r;

  always_comb begin
    in_item.is_elem   = in_ch.command;
    in_item.offset[0] = in_ch.offset_0;
    in_item.offset[1] = in_ch.offset_1;
    in_item.offset[2] = in_ch.offset_2;
    in_item.offset[3] = in_ch.offset_3;
    in_item.bext[0]   = clamp_ext(in_ch.block_extent_0, EXTENT_BITS);
    in_item.bext[1]   = clamp_ext(in_ch.block_extent_1, EXTENT_BITS);
    in_item.bext[2]   = clamp_ext(in_ch.block_extent_2, EXTENT_BITS);
    in_item.bext[3]   = clamp_ext(in_ch.block_extent_3, EXTENT_BITS);
    in_item.value     = in_ch.element_value;
  end

  assign in_ch.ready = (cnt_r != QCntW'(QueueDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_item      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCntW'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

/* rtl/core/bsag_back.sv */
// ----------------------------------------------------------------------------
// bsag_back
// Block set-up sequencer (strides, base, per-mode address steps over one shared
// multiplier) and the odometer, one address word per cycle when not stalled.
// ----------------------------------------------------------------------------
module bsag_back import bsag_pkg::*; #(
  parameter int RANK        = Rank,
  parameter int EXTENT_BITS = ExtentBits
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  bsag_item_t                     q_item,
  output logic                           q_pop,
  input  logic [NumFields-1:0][ExtW-1:0] dext,
  bsag_out_if.source                     out_ch
);

  localparam int ModeW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int CmpW  = ((EXTENT_BITS > ExtW) ? EXTENT_BITS : ExtW) + 1;

  bsag_state_t              state_r, state_nxt;
  bsag_phase_t              phase_r, phase_nxt;
  logic [ModeW-1:0]         mode_r, mode_nxt;
  bsag_item_t               beg_r, beg_nxt;
  logic [AddrW-1:0]         stride_r, stride_nxt;
  logic [AddrW-1:0]         span_r, span_nxt;
  logic [AddrW-1:0]         base_r, base_nxt;
  logic [AddrW-1:0]         prod_r, prod_nxt;
  logic [AddrW-1:0]         addr_r, addr_nxt;
  logic [AddrW-1:0]         step_r [RANK];
  logic [AddrW-1:0]         step_nxt [RANK];
  logic [ExtW-1:0]          ext_r [RANK];
  logic [ExtW-1:0]          ext_nxt [RANK];
  logic [EXTENT_BITS-1:0]   cnt_r [RANK];
  logic [EXTENT_BITS-1:0]   cnt_nxt [RANK];
  logic [EXTENT_BITS-1:0]   cnt_adv [RANK];
  logic                     out_valid_r, out_valid_nxt;
  logic [AddrW-1:0]         out_addr_r, out_addr_nxt;
  logic [ValW-1:0]          out_val_r, out_val_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     out_free, elem_go, beg_go, last_setup;
  logic [OffW-1:0]          off_sel;
  logic [ExtW-1:0]          bext_sel, dext_sel, mul_b;
  logic [AddrW-1:0]         mul_p;
  logic [RANK-1:0]          adv, atend;
  logic                     found, blk_last;
  logic [AddrW-1:0]         step_sel, addr_adv;

  // control outputs
  always_comb begin
    out_free   = !out_valid_r || out_ch.ready;
    elem_go    = (state_r == ST_RUN) && q_valid && q_item.is_elem && out_free;
    beg_go     = (state_r == ST_RUN) && q_valid && !q_item.is_elem;
    q_pop      = elem_go || beg_go;
    last_setup = (state_r == ST_SETUP) && (phase_r == PH_STRIDE) &&
                 (mode_r == ModeW'(RANK - 1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:   if (beg_go) state_nxt = ST_SETUP;
      ST_SETUP: if (last_setup) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  // per-mode field select, modes past the fields are offset 0, extent 1
  always_comb begin
    off_sel  = '0;
    bext_sel = ExtW'(1);
    dext_sel = ExtW'(1);
    for (int f = 0; f < NumFields; f++) begin
      if (int'(mode_r) == f) begin
        off_sel  = beg_r.offset[f];
        bext_sel = beg_r.bext[f];
        dext_sel = dext[f];
      end
    end
  end

  always_comb begin
    case (phase_r)
      PH_OFF:    mul_b = ExtW'(off_sel);
      PH_SPAN:   mul_b = bext_sel - ExtW'(1);
      PH_STRIDE: mul_b = dext_sel;
      default:   mul_b = '0;
    endcase
    mul_p = AddrW'(stride_r * mul_b);
  end

  // odometer
  always_comb begin
    found    = 1'b0;
    step_sel = '0;
    for (int m = 0; m < RANK; m++) begin
      adv[m]   = (CmpW'(cnt_r[m]) + CmpW'(1)) < CmpW'(ext_r[m]);
      atend[m] = CmpW'(cnt_r[m]) == (CmpW'(ext_r[m]) - CmpW'(1));
      cnt_adv[m] = cnt_r[m];
    end
    for (int m = 0; m < RANK; m++) begin
      if (!found) begin
        if (adv[m]) begin
          found      = 1'b1;
          cnt_adv[m] = cnt_r[m] + EXTENT_BITS'(1);
          step_sel   = step_r[m];
        end else begin
          cnt_adv[m] = '0;
        end
      end
    end
    blk_last = &atend;
    addr_adv = found ? addr_r + step_sel : base_r;
  end

  // datapath next values
  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    beg_nxt    = beg_r;
    stride_nxt = stride_r;
    span_nxt   = span_r;
    base_nxt   = base_r;
    prod_nxt   = prod_r;
    addr_nxt   = addr_r;
    step_nxt   = step_r;
    ext_nxt    = ext_r;
    cnt_nxt    = cnt_r;
    out_addr_nxt = out_addr_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;

    if (beg_go) begin
      beg_nxt    = q_item;
      stride_nxt = AddrW'(1);
      span_nxt   = '0;
      base_nxt   = '0;
      mode_nxt   = '0;
      phase_nxt  = PH_OFF;
    end

    if (state_r == ST_SETUP) begin
      case (phase_r)
        PH_OFF: begin
          step_nxt[mode_r] = stride_r - span_r;
          ext_nxt[mode_r]  = bext_sel;
          cnt_nxt[mode_r]  = '0;
          prod_nxt         = mul_p;
          phase_nxt        = PH_SPAN;
        end
        PH_SPAN: begin
          base_nxt  = base_r + prod_r;
          prod_nxt  = mul_p;
          phase_nxt = PH_STRIDE;
        end
        PH_STRIDE: begin
          span_nxt   = span_r + prod_r;
          stride_nxt = mul_p;
          phase_nxt  = PH_OFF;
          if (last_setup) begin
            addr_nxt = base_r;
          end else begin
            mode_nxt = mode_r + ModeW'(1);
          end
        end
        default: phase_nxt = PH_OFF;
      endcase
    end

    if (elem_go) begin
      cnt_nxt       = cnt_adv;
      addr_nxt      = addr_adv;
      out_valid_nxt = 1'b1;
      out_addr_nxt  = addr_r;
      out_val_nxt   = q_item.value;
      out_last_nxt  = blk_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      phase_r     <= PH_OFF;
      mode_r      <= '0;
      base_r      <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < RANK; m++) begin
        ext_r[m] <= ExtW'(1);
        cnt_r[m] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      base_r      <= base_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      ext_r       <= ext_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beg_r      <= beg_nxt;
    stride_r   <= stride_nxt;
    span_r     <= span_nxt;
    prod_r     <= prod_nxt;
    step_r     <= step_nxt;
    out_addr_r <= out_addr_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.dense_address = out_addr_r;
  assign out_ch.out_value     = out_val_r;
  assign out_ch.last_in_block = out_last_r;

endmodule

/* rtl/core/block_scatter_address_generator.sv */
// ----------------------------------------------------------------------------
// block_scatter_address_generator
// Column-major scatter addresses for the elements of one tensor block.
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      begin (offsets, extents) or element value
//   out_ch   out  valid/ready      dense address, value, last flag
//   cfg_*    in   cfg_we only      dense extent register write
//
// Element words run one per cycle through odometer and output register while
// no set-up runs and out_ch takes them. A begin word makes three passes of
// the shared stride multiplier per mode. A two-word queue sits between the
// front and the back, so input is taken while a result waits on out_ch.
// Reset (rst_n low, synchronous) clears queue, odometer and output valid.
// ----------------------------------------------------------------------------
module block_scatter_address_generator import bsag_pkg::*; #(
  parameter int RANK        = Rank,
  parameter int EXTENT_BITS = ExtentBits
) (
  input  logic               clk,
  input  logic               rst_n,
  bsag_in_if.sink            in_ch,
  bsag_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ExtW-1:0]    cfg_data
);

  logic                           q_valid;
  logic                           q_pop;
  bsag_item_t                     q_item;
  logic [NumFields-1:0][ExtW-1:0] dext;

  bsag_front #(
    .EXTENT_BITS (EXTENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .dext      (dext)
  );

  bsag_back #(
    .RANK        (RANK),
    .EXTENT_BITS (EXTENT_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .dext    (dext),
    .out_ch  (out_ch)
  );

endmodule
